>>> rtl/csrts_pkg.sv
`default_nettype none
package csrts_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF = 32;
  localparam int QUEUE_DEPTH    = 4;

  localparam int TAG_W    = 8;
  localparam int LIMIT_W  = 8;
  localparam int SIFS_W   = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int TOTAL_W  = 32;

  localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RST = 8'd10;
  localparam logic [SIFS_W-1:0]  SIFS_TICKS_RST  = 16'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RTS_CTS_ENABLE = 2'd0,
    REG_RETRY_LIMIT    = 2'd1,
    REG_SIFS_TICKS     = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_GRANT = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_FRAME = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TURN = 2'd1,
    PH_CTS  = 2'd2,
    PH_ACK  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ACT_REQ  = 3'd0,
    ACT_RTS  = 3'd1,
    ACT_DATA = 3'd2,
    ACT_FB   = 3'd3,
    ACT_DONE = 3'd4
  } act_t;

  typedef struct packed {
    act_t             act;
    logic [TAG_W-1:0] tag;
    logic             ack_ok;
    logic             success;
  } res_t;

  // One queue record: the results of one item plus status after the step.
  typedef struct packed {
    res_t               r0;
    res_t               r1;
    logic               two;
    logic               auto_reply;
    logic [TOTAL_W-1:0] retries;
    logic [TOTAL_W-1:0] failures;
    logic [TOTAL_W-1:0] successes;
  } rec_t;

endpackage
`default_nettype wire

>>> rtl/csrts_engine.sv
`default_nettype none
module csrts_engine #(
  parameter int TIMER_BITS = csrts_pkg::TIMER_BITS_DEF,
  parameter int COUNT_BITS = csrts_pkg::COUNT_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [csrts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [csrts_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                               accept,
  input  wire logic [1:0]                         kind,
  input  wire logic [csrts_pkg::TAG_W-1:0]        packet_tag,
  input  wire logic                               frame_valid,
  input  wire logic                               frame_is_cts,
  input  wire logic                               frame_is_ack,
  output logic                                    push,
  output csrts_pkg::rec_t                         rec
);

  localparam int CW = (TIMER_BITS > csrts_pkg::SIFS_W) ? TIMER_BITS : csrts_pkg::SIFS_W;

  logic                            rts_cts_enable;
  logic [csrts_pkg::LIMIT_W-1:0]   attempt_limit;
  logic [csrts_pkg::SIFS_W-1:0]    sifs_ticks;

  csrts_pkg::phase_t               phase, phase_next;
  logic [csrts_pkg::LIMIT_W-1:0]   attempt_count, attempt_count_next;
  logic [TIMER_BITS-1:0]           wait_timer, wait_timer_next;
  logic [csrts_pkg::TAG_W-1:0]     held_tag, held_tag_next;
  logic                            auto_reply, auto_reply_next;
  logic [COUNT_BITS-1:0]           retry_counter, retry_counter_next;
  logic [COUNT_BITS-1:0]           failure_counter, failure_counter_next;
  logic [COUNT_BITS-1:0]           success_counter, success_counter_next;

  logic [TIMER_BITS-1:0]           timer_inc;
  logic                            timeout;
  logic [csrts_pkg::LIMIT_W-1:0]   fail_att;
  logic                            do_fail;
  logic                            do_data;
  logic                            has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      rts_cts_enable <= 1'b1;
      attempt_limit  <= csrts_pkg::RETRY_LIMIT_RST;
      sifs_ticks     <= csrts_pkg::SIFS_TICKS_RST;
    end else if (cfg_we) begin
      case (csrts_pkg::reg_idx_t'(cfg_index))
        csrts_pkg::REG_RTS_CTS_ENABLE: rts_cts_enable <= cfg_data[0];
        csrts_pkg::REG_RETRY_LIMIT:    attempt_limit  <= cfg_data[csrts_pkg::LIMIT_W-1:0];
        csrts_pkg::REG_SIFS_TICKS:     sifs_ticks     <= cfg_data[csrts_pkg::SIFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= csrts_pkg::PH_IDLE;
      attempt_count   <= '0;
      wait_timer      <= '0;
      held_tag        <= '0;
      auto_reply      <= 1'b1;
      retry_counter   <= '0;
      failure_counter <= '0;
      success_counter <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      attempt_count   <= attempt_count_next;
      wait_timer      <= wait_timer_next;
      held_tag        <= held_tag_next;
      auto_reply      <= auto_reply_next;
      retry_counter   <= retry_counter_next;
      failure_counter <= failure_counter_next;
      success_counter <= success_counter_next;
    end
  end

  always_comb begin
    phase_next           = phase;
    attempt_count_next   = attempt_count;
    wait_timer_next      = wait_timer;
    held_tag_next        = held_tag;
    auto_reply_next      = auto_reply;
    retry_counter_next   = retry_counter;
    failure_counter_next = failure_counter;
    success_counter_next = success_counter;
    rec        = '0;
    has_result = 1'b0;
    do_fail    = 1'b0;
    do_data    = 1'b0;

    // saturate the wait timer
    timer_inc = (wait_timer == {TIMER_BITS{1'b1}}) ? wait_timer
                                                    : TIMER_BITS'(wait_timer + 1'b1);
    timeout   = CW'(timer_inc) >= CW'(sifs_ticks);
    fail_att  = attempt_count + 8'd1;

    case (csrts_pkg::kind_t'(kind))
      csrts_pkg::KIND_START: begin
        if (phase == csrts_pkg::PH_IDLE) begin
          held_tag_next      = packet_tag;
          attempt_count_next = '0;
          has_result         = 1'b1;
          if (attempt_limit == '0) begin
            failure_counter_next = failure_counter + 1'b1;
            phase_next           = csrts_pkg::PH_IDLE;
            rec.r0.act           = csrts_pkg::ACT_DONE;
          end else begin
            phase_next = csrts_pkg::PH_TURN;
            rec.r0.act = csrts_pkg::ACT_REQ;
          end
        end
      end
      csrts_pkg::KIND_GRANT: begin
        if (phase == csrts_pkg::PH_TURN) begin
          if (rts_cts_enable) begin
            auto_reply_next = 1'b0;
            wait_timer_next = '0;
            phase_next      = csrts_pkg::PH_CTS;
            rec.r0.act      = csrts_pkg::ACT_RTS;
            has_result      = 1'b1;
          end else begin
            do_data = 1'b1;
          end
        end
      end
      csrts_pkg::KIND_TICK: begin
        if (phase == csrts_pkg::PH_CTS || phase == csrts_pkg::PH_ACK) begin
          wait_timer_next = timer_inc;
          if (timeout) begin
            auto_reply_next = 1'b1;
            do_fail         = 1'b1;
          end
        end
      end
      csrts_pkg::KIND_FRAME: begin
        if (phase == csrts_pkg::PH_CTS) begin
          // an invalid frame counts as the expected one
          if (frame_valid && !frame_is_cts) do_fail = 1'b1;
          else do_data = 1'b1;
        end else if (phase == csrts_pkg::PH_ACK) begin
          auto_reply_next = 1'b1;
          if (frame_valid && !frame_is_ack) begin
            do_fail = 1'b1;
          end else begin
            success_counter_next = success_counter + 1'b1;
            phase_next           = csrts_pkg::PH_IDLE;
            has_result           = 1'b1;
            rec.two              = 1'b1;
            rec.r0.act           = csrts_pkg::ACT_FB;
            rec.r0.ack_ok        = 1'b1;
            rec.r1.act           = csrts_pkg::ACT_DONE;
            rec.r1.success       = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (do_data) begin
      auto_reply_next = 1'b0;
      wait_timer_next = '0;
      phase_next      = csrts_pkg::PH_ACK;
      rec.r0.act      = csrts_pkg::ACT_DATA;
      rec.r0.tag      = held_tag;
      has_result      = 1'b1;
    end

    if (do_fail) begin
      attempt_count_next = fail_att;
      retry_counter_next = retry_counter + 1'b1;
      has_result         = 1'b1;
      rec.two            = 1'b1;
      rec.r0.act         = csrts_pkg::ACT_FB;
      if (fail_att >= attempt_limit) begin
        failure_counter_next = failure_counter + 1'b1;
        phase_next           = csrts_pkg::PH_IDLE;
        rec.r1.act           = csrts_pkg::ACT_DONE;
      end else begin
        phase_next = csrts_pkg::PH_TURN;
        rec.r1.act = csrts_pkg::ACT_REQ;
      end
    end

    rec.auto_reply = auto_reply_next;
    rec.retries    = csrts_pkg::TOTAL_W'(retry_counter_next);
    rec.failures   = csrts_pkg::TOTAL_W'(failure_counter_next);
    rec.successes  = csrts_pkg::TOTAL_W'(success_counter_next);
    push           = accept && has_result;
  end

endmodule
`default_nettype wire

>>> rtl/csrts_fifo.sv
`default_nettype none
module csrts_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = csrts_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  full,
  output logic                  nonempty,
  output logic [WIDTH-1:0]      rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr, rptr;
  logic [CNTW-1:0]  count;

  assign full     = (count == CNTW'(DEPTH));
  assign nonempty = (count != '0);
  assign rdata    = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : PW'(wptr + 1'b1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : PW'(rptr + 1'b1);
      end
      if (push && !pop) count <= CNTW'(count + 1'b1);
      else if (pop && !push) count <= CNTW'(count - 1'b1);
    end
  end

endmodule
`default_nettype wire

>>> rtl/csrts_emit.sv
`default_nettype none
module csrts_emit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_nonempty,
  input  wire csrts_pkg::rec_t               q_rec,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [2:0]                         action,
  output logic [csrts_pkg::TAG_W-1:0]        tx_tag,
  output logic                               ack_ok,
  output logic                               success,
  output logic                               auto_reply_enabled,
  output logic [csrts_pkg::TOTAL_W-1:0]      retries_total,
  output logic [csrts_pkg::TOTAL_W-1:0]      failures_total,
  output logic [csrts_pkg::TOTAL_W-1:0]      successes_total,
  output logic                               last
);

  logic            sel;
  logic            xfer;
  csrts_pkg::res_t res;

  assign out_valid = q_nonempty;
  assign xfer      = out_valid && !out_stall;
  assign last      = !q_rec.two || sel;
  // drop the record once its final result is transferred
  assign pop       = xfer && last;
  assign res       = sel ? q_rec.r1 : q_rec.r0;

  assign action             = res.act;
  assign tx_tag             = res.tag;
  assign ack_ok             = res.ack_ok;
  assign success            = res.success;
  assign auto_reply_enabled = q_rec.auto_reply;
  assign retries_total      = q_rec.retries;
  assign failures_total     = q_rec.failures;
  assign successes_total    = q_rec.successes;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (xfer) begin
      sel <= !last;
    end
  end

endmodule
`default_nettype wire

>>> rtl/csma_rts_cts_sender_top.sv
// Flow: an accepted item's results are queued, and its first result shows on the output
//   once it reaches the queue head, its second result (if any) one transfer later.
// Throughput: one item per cycle unless the queue is full; two results hold the output for
//   two transfers; a four-record queue between the protocol engine and output absorbs it.
// Reset (synchronous, rst high): idle, counters and timer zero, auto reply on,
//   registers back to RTS/CTS on, retry limit 10, SIFS 16 ticks; queue empty.
`default_nettype none
module csma_rts_cts_sender_top #(
  parameter int TIMER_BITS = csrts_pkg::TIMER_BITS_DEF,
  parameter int COUNT_BITS = csrts_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [csrts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [csrts_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    kind,
  input  wire logic [csrts_pkg::TAG_W-1:0]   packet_tag,
  input  wire logic                          frame_valid,
  input  wire logic                          frame_is_cts,
  input  wire logic                          frame_is_ack,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [2:0]                         action,
  output logic [csrts_pkg::TAG_W-1:0]        tx_tag,
  output logic                               ack_ok,
  output logic                               success,
  output logic                               auto_reply_enabled,
  output logic [csrts_pkg::TOTAL_W-1:0]      retries_total,
  output logic [csrts_pkg::TOTAL_W-1:0]      failures_total,
  output logic [csrts_pkg::TOTAL_W-1:0]      successes_total,
  output logic                               last
);

  logic            accept;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_nonempty;
  csrts_pkg::rec_t wrec;
  csrts_pkg::rec_t q_rec;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  csrts_engine #(
    .TIMER_BITS (TIMER_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .kind         (kind),
    .packet_tag   (packet_tag),
    .frame_valid  (frame_valid),
    .frame_is_cts (frame_is_cts),
    .frame_is_ack (frame_is_ack),
    .push         (push),
    .rec          (wrec)
  );

  csrts_fifo #(
    .WIDTH ($bits(csrts_pkg::rec_t)),
    .DEPTH (csrts_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (wrec),
    .pop      (pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .rdata    (q_rec)
  );

  csrts_emit u_emit (
    .clk                (clk),
    .rst                (rst),
    .q_nonempty         (q_nonempty),
    .q_rec              (q_rec),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .action             (action),
    .tx_tag             (tx_tag),
    .ack_ok             (ack_ok),
    .success            (success),
    .auto_reply_enabled (auto_reply_enabled),
    .retries_total      (retries_total),
    .failures_total     (failures_total),
    .successes_total    (successes_total),
    .last               (last)
  );

  // backoff feedback is always followed by a second result of the same item
  a_fb_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == csrts_pkg::ACT_FB |-> !last)
    else $error("feedback marked as final result");

  a_success_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && success |-> action == csrts_pkg::ACT_DONE && last)
    else $error("success flag outside a final finished result");

  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid)
    else $error("second result of an item went missing");

  a_data_tag_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && action != csrts_pkg::ACT_DATA |-> tx_tag == '0)
    else $error("tag driven on a result that sends no data");

endmodule
`default_nettype wire

>>> tb/sv/csma_rts_cts_sender_checker.sv
module csma_rts_cts_sender_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [csrts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csrts_pkg::CFG_W-1:0]   cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [1:0]                    kind,
  input  logic [csrts_pkg::TAG_W-1:0]   packet_tag,
  input  logic                          frame_valid,
  input  logic                          frame_is_cts,
  input  logic                          frame_is_ack,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [2:0]                    action,
  input  logic [csrts_pkg::TAG_W-1:0]   tx_tag,
  input  logic                          ack_ok,
  input  logic                          success,
  input  logic                          auto_reply_enabled,
  input  logic [csrts_pkg::TOTAL_W-1:0] retries_total,
  input  logic [csrts_pkg::TOTAL_W-1:0] failures_total,
  input  logic [csrts_pkg::TOTAL_W-1:0] successes_total,
  input  logic                          last,
  output int                            fail_count,
  output int                            pending,
  output int                            results_seen,
  output int                            delivered,
  output int                            abandoned
);
  import csrts_pkg::*;

  typedef struct packed {
    act_t               act;
    logic [TAG_W-1:0]   tag;
    logic               ack_ok;
    logic               success;
    logic               auto_reply;
    logic [TOTAL_W-1:0] retries;
    logic [TOTAL_W-1:0] failures;
    logic [TOTAL_W-1:0] successes;
    logic               last;
  } sender_result_t;

  // register copies
  logic               rts_on;
  logic [LIMIT_W-1:0] limit_reg;
  logic [SIFS_W-1:0]  sifs_reg;

  // protocol state
  phase_t             phase;
  logic [LIMIT_W-1:0] attempts;
  logic [SIFS_W-1:0]  wait_ticks;
  logic [TAG_W-1:0]   held_tag;
  logic               auto_reply;
  logic [TOTAL_W-1:0] retries;
  logic [TOTAL_W-1:0] failures;
  logic [TOTAL_W-1:0] successes;

  sender_result_t step_results[$];
  sender_result_t expected_results[$];
  sender_result_t got;

  function automatic void add_result(act_t act, logic [TAG_W-1:0] tag, logic ok, logic delivered_bit);
    sender_result_t r;
    r = '0;
    r.act = act;
    r.tag = tag;
    r.ack_ok = ok;
    r.success = delivered_bit;
    step_results.push_back(r);
  endfunction

  // give up once the attempt count reaches the limit, else ask for the channel
  function automatic void begin_attempt();
    if (attempts >= limit_reg) begin
      failures = failures + 1'b1;
      phase = PH_IDLE;
      add_result(ACT_DONE, '0, 1'b0, 1'b0);
    end else begin
      phase = PH_TURN;
      add_result(ACT_REQ, '0, 1'b0, 1'b0);
    end
  endfunction

  function automatic void start_data_frame();
    auto_reply = 1'b0;
    wait_ticks = '0;
    phase = PH_ACK;
    add_result(ACT_DATA, held_tag, 1'b0, 1'b0);
  endfunction

  function automatic void fail_exchange();
    attempts = attempts + 1'b1;
    retries = retries + 1'b1;
    add_result(ACT_FB, '0, 1'b0, 1'b0);
    begin_attempt();
  endfunction

  function automatic void sender_step(kind_t k, logic [TAG_W-1:0] tag, logic fv, logic fc,
                                      logic fa);
    sender_result_t r;
    step_results.delete();
    case (k)
      KIND_START: begin
        if (phase == PH_IDLE) begin
          held_tag = tag;
          attempts = '0;
          begin_attempt();
        end
      end
      KIND_GRANT: begin
        if (phase == PH_TURN) begin
          if (rts_on) begin
            auto_reply = 1'b0;
            wait_ticks = '0;
            phase = PH_CTS;
            add_result(ACT_RTS, '0, 1'b0, 1'b0);
          end else begin
            start_data_frame();
          end
        end
      end
      KIND_TICK: begin
        if (phase == PH_CTS || phase == PH_ACK) begin
          // timer saturates
          if (wait_ticks != '1) wait_ticks = wait_ticks + 1'b1;
          if (wait_ticks >= sifs_reg) begin
            auto_reply = 1'b1;
            fail_exchange();
          end
        end
      end
      default: begin
        if (phase == PH_CTS) begin
          // an invalid frame counts as acceptance
          if (fv && !fc) fail_exchange();
          else start_data_frame();
        end else if (phase == PH_ACK) begin
          auto_reply = 1'b1;
          if (fv && !fa) begin
            fail_exchange();
          end else begin
            successes = successes + 1'b1;
            phase = PH_IDLE;
            add_result(ACT_FB, '0, 1'b1, 1'b0);
            add_result(ACT_DONE, '0, 1'b0, 1'b1);
          end
        end
      end
    endcase
    // status fields reflect the state after the whole step
    foreach (step_results[i]) begin
      r = step_results[i];
      r.auto_reply = auto_reply;
      r.retries = retries;
      r.failures = failures;
      r.successes = successes;
      r.last = (i == step_results.size() - 1);
      expected_results.push_back(r);
    end
  endfunction

  function automatic void check_field(string field, logic [TOTAL_W-1:0] want,
                                      logic [TOTAL_W-1:0] seen);
    if (seen !== want) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, seen);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rts_on = 1'b1;
      limit_reg = RETRY_LIMIT_RST;
      sifs_reg = SIFS_TICKS_RST;
      phase = PH_IDLE;
      attempts = '0;
      wait_ticks = '0;
      held_tag = '0;
      auto_reply = 1'b1;
      retries = '0;
      failures = '0;
      successes = '0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_RTS_CTS_ENABLE: rts_on = cfg_data[0];
          REG_RETRY_LIMIT:    limit_reg = cfg_data[LIMIT_W-1:0];
          REG_SIFS_TICKS:     sifs_reg = cfg_data[SIFS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        sender_step(kind_t'(kind), packet_tag, frame_valid, frame_is_cts, frame_is_ack);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected: expected none, actual action %0h",
                   $time, action);
        end else begin
          got = expected_results.pop_front();
          check_field("action", got.act, action);
          check_field("tx_tag", got.tag, tx_tag);
          check_field("ack_ok", got.ack_ok, ack_ok);
          check_field("success", got.success, success);
          check_field("auto_reply_enabled", got.auto_reply, auto_reply_enabled);
          check_field("retries_total", got.retries, retries_total);
          check_field("failures_total", got.failures, failures_total);
          check_field("successes_total", got.successes, successes_total);
          check_field("last", got.last, last);
          results_seen++;
          if (got.act == ACT_DONE) begin
            if (got.success) delivered++;
            else abandoned++;
          end
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

>>> tb/sv/csma_rts_cts_sender_top_tb.sv
module csma_rts_cts_sender_top_tb;
  import csrts_pkg::*;

  localparam int LONG_HOLD  = 300;
  localparam int RUN_LIMIT  = 400000;
  localparam int PHASE_ITEMS = 200;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  reg_idx_t             cfg_index = REG_RTS_CTS_ENABLE;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  kind_t                kind = KIND_START;
  logic [TAG_W-1:0]     packet_tag = '0;
  logic                 frame_valid = 1'b0;
  logic                 frame_is_cts = 1'b0;
  logic                 frame_is_ack = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           action;
  logic [TAG_W-1:0]     tx_tag;
  logic                 ack_ok;
  logic                 success;
  logic                 auto_reply_enabled;
  logic [TOTAL_W-1:0]   retries_total;
  logic [TOTAL_W-1:0]   failures_total;
  logic [TOTAL_W-1:0]   successes_total;
  logic                 last;

  int fail_count;
  int pending;
  int results_seen;
  int delivered;
  int abandoned;

  int send_idle_pct = 16;
  int recv_idle_pct = 73;
  int items_sent = 0;
  logic hold_req = 1'b0;
  bit hold_done = 1'b0;

  // settings the stimulus plans against
  bit                 cur_rts = 1'b1;
  logic [LIMIT_W-1:0] cur_limit = RETRY_LIMIT_RST;
  logic [SIFS_W-1:0]  cur_sifs = SIFS_TICKS_RST;

  always #4 clk = ~clk;

  csma_rts_cts_sender_top i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .packet_tag(packet_tag), .frame_valid(frame_valid),
    .frame_is_cts(frame_is_cts), .frame_is_ack(frame_is_ack),
    .out_valid(out_valid), .out_stall(out_stall),
    .action(action), .tx_tag(tx_tag), .ack_ok(ack_ok), .success(success),
    .auto_reply_enabled(auto_reply_enabled), .retries_total(retries_total),
    .failures_total(failures_total), .successes_total(successes_total), .last(last)
  );

  csma_rts_cts_sender_checker i_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .packet_tag(packet_tag), .frame_valid(frame_valid),
    .frame_is_cts(frame_is_cts), .frame_is_ack(frame_is_ack),
    .out_valid(out_valid), .out_stall(out_stall),
    .action(action), .tx_tag(tx_tag), .ack_ok(ack_ok), .success(success),
    .auto_reply_enabled(auto_reply_enabled), .retries_total(retries_total),
    .failures_total(failures_total), .successes_total(successes_total), .last(last),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen),
    .delivered(delivered), .abandoned(abandoned)
  );

  // receiver: random stalls, plus one long hold-off once requested
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        repeat (LONG_HOLD) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
        @(posedge clk);
      end
    end
  end

  initial begin
    #(RUN_LIMIT * 8);
    $display("status: fail");
    $finish;
  end

  task automatic offer(kind_t k, logic [TAG_W-1:0] tag, logic fv, logic fc, logic fa);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    packet_tag <= tag;
    frame_valid <= fv;
    frame_is_cts <= fc;
    frame_is_ack <= fa;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic maybe_noise();
    if ($urandom_range(99) < 7)
      offer(kind_t'($urandom_range(3)), TAG_W'($urandom), 1'($urandom), 1'($urandom),
            1'($urandom));
  endtask

  // hold off input until all results are out and the engine has settled
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < 100000);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(bit rts, logic [LIMIT_W-1:0] lim, logic [SIFS_W-1:0] sifs);
    cfg_we <= 1'b1;
    cfg_index <= REG_RTS_CTS_ENABLE;
    cfg_data <= CFG_W'(rts);
    @(posedge clk);
    cfg_index <= REG_RETRY_LIMIT;
    cfg_data <= CFG_W'(lim);
    @(posedge clk);
    cfg_index <= REG_SIFS_TICKS;
    cfg_data <= sifs;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_rts = rts;
    cur_limit = lim;
    cur_sifs = sifs;
  endtask

  // answer an RTS or data transfer: timeout, or a short tick run and a good, invalid or wrong frame
  task automatic answer(input bit want_cts, output bit accepted);
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 15) begin
      repeat ((cur_sifs == 0) ? 1 : int'(cur_sifs)) begin
        maybe_noise();
        offer(KIND_TICK, TAG_W'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      end
      accepted = 1'b0;
    end else begin
      n = (cur_sifs > 1) ? $urandom_range((cur_sifs - 1 > 8) ? 8 : cur_sifs - 1, 0) : 0;
      repeat (n)
        offer(KIND_TICK, TAG_W'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      maybe_noise();
      if (r < 70) begin
        offer(KIND_FRAME, TAG_W'($urandom), 1'b1, want_cts ? 1'b1 : 1'($urandom),
              want_cts ? 1'($urandom) : 1'b1);
        accepted = 1'b1;
      end else if (r < 85) begin
        offer(KIND_FRAME, TAG_W'($urandom), 1'b0, 1'($urandom), 1'($urandom));
        accepted = 1'b1;
      end else begin
        offer(KIND_FRAME, TAG_W'($urandom), 1'b1, want_cts ? 1'b0 : 1'($urandom),
              want_cts ? 1'($urandom) : 1'b0);
        accepted = 1'b0;
      end
    end
  endtask

  task automatic run_packet();
    int tries;
    bit ok;
    bit done;
    maybe_noise();
    offer(KIND_START, TAG_W'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    tries = 0;
    done = (cur_limit == 0);
    while (!done) begin
      maybe_noise();
      offer(KIND_GRANT, TAG_W'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      ok = 1'b1;
      if (cur_rts) answer(1'b1, ok);
      if (ok) answer(1'b0, ok);
      if (ok) begin
        done = 1'b1;
      end else begin
        tries++;
        if (tries >= cur_limit) done = 1'b1;
      end
    end
  endtask

  initial begin
    int target;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: RTS/CTS on, limit 10, 16 ticks
    offer(KIND_START, 8'hFF, 1'b0, 1'b0, 1'b0);
    offer(KIND_START, 8'h00, 1'b1, 1'b1, 1'b1);   // busy: dropped
    offer(KIND_TICK,  8'h00, 1'b0, 1'b0, 1'b0);   // not waiting: dropped
    offer(KIND_FRAME, 8'h00, 1'b1, 1'b1, 1'b1);
    offer(KIND_GRANT, 8'h00, 1'b0, 1'b0, 1'b0);
    offer(KIND_GRANT, 8'h00, 1'b0, 1'b0, 1'b0);
    offer(KIND_FRAME, 8'h00, 1'b1, 1'b1, 1'b0);
    offer(KIND_FRAME, 8'h00, 1'b1, 1'b0, 1'b1);
    offer(KIND_FRAME, 8'h00, 1'b1, 1'b0, 1'b1);   // idle: dropped
    offer(KIND_TICK,  8'h00, 1'b0, 1'b0, 1'b0);
    offer(KIND_GRANT, 8'h00, 1'b0, 1'b0, 1'b0);
    offer(KIND_START, 8'h00, 1'b0, 1'b0, 1'b0);
    offer(KIND_GRANT, 8'hFF, 1'b0, 1'b0, 1'b0);
    offer(KIND_FRAME, 8'hFF, 1'b1, 1'b0, 1'b1);   // ACK while waiting for CTS
    offer(KIND_GRANT, 8'h00, 1'b0, 1'b0, 1'b0);
    offer(KIND_FRAME, 8'h00, 1'b0, 1'b1, 1'b1);   // bad frame taken as CTS
    offer(KIND_FRAME, 8'h00, 1'b1, 1'b1, 1'b0);   // CTS while waiting for ACK
    drain();
    // lower the limit mid-send, zero wait: first tick times out
    set_config(1'b0, 8'd1, 16'd0);
    offer(KIND_GRANT, 8'h00, 1'b0, 1'b0, 1'b0);
    offer(KIND_TICK,  8'h00, 1'b0, 1'b0, 1'b0);
    drain();
    set_config(1'b1, 8'd0, 16'hFFFF);
    offer(KIND_START, 8'hAA, 1'b0, 1'b0, 1'b0);   // gives up at once
    drain();
    set_config(1'b0, 8'hFF, 16'hFFFF);
    offer(KIND_START, 8'h55, 1'b0, 1'b0, 1'b0);
    offer(KIND_GRANT, 8'h00, 1'b0, 1'b0, 1'b0);
    offer(KIND_FRAME, 8'h00, 1'b1, 1'b0, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      if (ph < 3) begin
        send_idle_pct = 16;
        recv_idle_pct = 73;
      end else if (ph < 6) begin
        send_idle_pct = 73;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_config(ph[0],
                 (ph == 2) ? 8'd0 : (ph == 5) ? 8'hFF : LIMIT_W'($urandom_range(4, 1)),
                 (ph == 4) ? 16'd0 : (ph == 7) ? 16'd1 : SIFS_W'($urandom_range(6, 2)));
      // stall the output long enough for the block to back up its input
      if (ph == 6) hold_req <= 1'b1;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) run_packet();
    end

    drain();
    $display("covered %0d input transfers over RTS/CTS on and off, retry limits 0 to 255,",
             items_sent);
    $display("wait lengths 0 to 65535 ticks and one long output hold: %0d results, %0d %s",
             results_seen, delivered, $sformatf("delivered, %0d given up", abandoned));
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> csma_rts_cts_sender_top.f
rtl/csrts_pkg.sv
rtl/csrts_engine.sv
rtl/csrts_fifo.sv
rtl/csrts_emit.sv
rtl/csma_rts_cts_sender_top.sv
tb/sv/csma_rts_cts_sender_checker.sv
tb/sv/csma_rts_cts_sender_top_tb.sv
